@@ hw/rtl/clns_pkg.sv @@
// Shared types, codes and the init command table for the LCD nibble sequencer.
package clns_pkg;

	localparam int unsigned HoldW = 16;
	localparam int unsigned NumInitCmds = 9;
	localparam int unsigned CmdIdxW = $clog2(NumInitCmds);

	typedef logic [1:0] op_t;
	localparam op_t OP_INIT  = 2'd0;
	localparam op_t OP_CMD   = 2'd1;
	localparam op_t OP_DATA  = 2'd2;
	localparam op_t OP_CLEAR = 2'd3;

	typedef logic [2:0] reg_idx_t;
	localparam reg_idx_t REG_ENABLE_HOLD = 3'd0;
	localparam reg_idx_t REG_COMMAND_GAP = 3'd1;
	localparam reg_idx_t REG_RESET_GAP   = 3'd2;
	localparam reg_idx_t REG_POWER_UP    = 3'd3;
	localparam reg_idx_t REG_CLEAR_WAIT  = 3'd4;

	localparam logic [7:0] CLEAR_CMD = 8'h01;

	typedef struct packed {
		logic [HoldW-1:0] enable_hold_us;
		logic [HoldW-1:0] command_gap_us;
		logic [HoldW-1:0] reset_gap_us;
		logic [HoldW-1:0] power_up_wait_us;
		logic [HoldW-1:0] clear_wait_us;
	} cfg_t;

	function automatic logic [7:0] init_cmd(input logic [CmdIdxW-1:0] idx);
		logic [7:0] c;
		unique case (idx)
			4'd0: c = 8'h30;
			4'd1: c = 8'h30;
			4'd2: c = 8'h30;
			4'd3: c = 8'h20;
			4'd4: c = 8'h28;
			4'd5: c = 8'h08;
			4'd6: c = 8'h01;
			4'd7: c = 8'h06;
			default: c = 8'h0c;
		endcase
		return c;
	endfunction

endpackage

@@ hw/rtl/clns_if.sv @@
// Valid/ready channel interfaces: operation input, phase output, register writes.
interface clns_op_if;
	logic       valid;
	logic       ready;
	logic [1:0] op;
	logic [7:0] value;
	modport source (output valid, output op, output value, input ready);
	modport sink (input valid, input op, input value, output ready);
endinterface

interface clns_phase_if;
	logic        valid;
	logic        ready;
	logic        reg_select;
	logic        enable;
	logic [3:0]  nibble;
	logic [15:0] hold_us;
	logic        last;
	modport source (output valid, output reg_select, output enable, output nibble,
		output hold_us, output last, input ready);
	modport sink (input valid, input reg_select, input enable, input nibble,
		input hold_us, input last, output ready);
endinterface

interface clns_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [15:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/char_lcd_nibble_sequencer_unit.sv @@
// Top level: character LCD 4-bit nibble sequencer.
// One phase leaves the sequencer per cycle while the phase channel takes them.
// Command and data bytes send each nibble with enable high, then low; clear and
// each init command but the last add a gap phase, and initialization opens with a
// power-up wait. A new operation is taken once the last phase has been generated.
// Reset clears the sequencer and loads the timing registers with defaults.
module char_lcd_nibble_sequencer_unit
	import clns_pkg::*;
(
	input logic          clk,
	input logic          arst_n,
	clns_op_if.sink      cmd,
	clns_phase_if.source phase,
	clns_cfg_if.sink     cfg
);

	cfg_t regs;

	clns_cfg_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	clns_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.regs   (regs),
		.cmd    (cmd),
		.phase  (phase)
	);

`ifndef SYNTHESIS
	a_busy_while_phase: assert property (@(posedge clk) disable iff (!arst_n)
		phase.valid && !phase.last |-> !cmd.ready)
		else $error("operation taken while phases remain");
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid && cmd.ready |=> !cmd.ready)
		else $error("sequencer idle right after operation transfer");
	a_last_not_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		phase.valid && phase.enable |-> !phase.last)
		else $error("last phase with enable high");
`endif

endmodule

@@ hw/rtl/clns_cfg_regs.sv @@
// Timing register file written through the configuration channel.
module clns_cfg_regs
	import clns_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	clns_cfg_if.sink   cfg,
	output cfg_t       regs
);

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.enable_hold_us   <= 16'd30;
			regs_q.command_gap_us   <= 16'd200;
			regs_q.reset_gap_us     <= 16'd5000;
			regs_q.power_up_wait_us <= 16'd45000;
			regs_q.clear_wait_us    <= 16'd2000;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_ENABLE_HOLD: regs_q.enable_hold_us   <= cfg.data;
				REG_COMMAND_GAP: regs_q.command_gap_us   <= cfg.data;
				REG_RESET_GAP:   regs_q.reset_gap_us     <= cfg.data;
				REG_POWER_UP:    regs_q.power_up_wait_us <= cfg.data;
				REG_CLEAR_WAIT:  regs_q.clear_wait_us    <= cfg.data;
				default: ;
			endcase
		end
	end

endmodule

@@ hw/rtl/clns_seq.sv @@
// Phase sequencer: steps command index and phase counter, one phase per transfer.
module clns_seq
	import clns_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  cfg_t         regs,
	clns_op_if.sink      cmd,
	clns_phase_if.source phase
);

	localparam logic [2:0] PH_HI_EN = 3'd0;
	localparam logic [2:0] PH_LO_DIS = 3'd3;
	localparam logic [2:0] PH_GAP = 3'd4;

	logic               busy_q;
	logic               pu_q;
	op_t                op_q;
	logic [7:0]         val_q;
	logic [CmdIdxW-1:0] cmd_idx_q;
	logic [2:0]         ph_q;

	logic        out_vld_q;
	logic        rs_q;
	logic        en_q;
	logic [3:0]  nib_q;
	logic [15:0] hold_q;
	logic        last_q;

	logic        fire;
	logic [7:0]  byte_sel;
	logic        nx_rs;
	logic        nx_en;
	logic [3:0]  nx_nib;
	logic [15:0] nx_hold;
	logic        nx_last;

	assign cmd.ready        = !busy_q;
	assign phase.valid      = out_vld_q;
	assign phase.reg_select = rs_q;
	assign phase.enable     = en_q;
	assign phase.nibble     = nib_q;
	assign phase.hold_us    = hold_q;
	assign phase.last       = last_q;

	assign fire = busy_q && (!out_vld_q || phase.ready);

	always_comb begin
		priority if (op_q == OP_INIT) byte_sel = init_cmd(cmd_idx_q);
		else if (op_q == OP_CLEAR) byte_sel = CLEAR_CMD;
		else byte_sel = val_q;

		nx_rs   = (op_q == OP_DATA);
		nx_en   = !ph_q[0];
		nx_nib  = ph_q[1] ? byte_sel[3:0] : byte_sel[7:4];
		nx_hold = regs.enable_hold_us;
		nx_last = 1'b0;
		priority if (pu_q) begin
			nx_rs   = 1'b0;
			nx_en   = 1'b0;
			nx_nib  = 4'd0;
			nx_hold = regs.power_up_wait_us;
		end else if (ph_q == PH_GAP) begin
			nx_rs   = 1'b0;
			nx_en   = 1'b0;
			nx_nib  = byte_sel[3:0];
			if (op_q == OP_CLEAR) begin
				nx_hold = regs.clear_wait_us;
				nx_last = 1'b1;
			end else if (cmd_idx_q == '0) begin
				nx_hold = regs.reset_gap_us;
			end else begin
				nx_hold = regs.command_gap_us;
			end
		end else if (ph_q == PH_LO_DIS) begin
			if (op_q == OP_INIT)
				nx_last = (cmd_idx_q == CmdIdxW'(NumInitCmds - 1));
			else
				nx_last = (op_q != OP_CLEAR);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			pu_q      <= 1'b0;
			out_vld_q <= 1'b0;
			cmd_idx_q <= '0;
			ph_q      <= PH_HI_EN;
		end else begin
			if (fire)
				out_vld_q <= 1'b1;
			else if (phase.valid && phase.ready)
				out_vld_q <= 1'b0;
			if (cmd.valid && cmd.ready) begin
				busy_q    <= 1'b1;
				pu_q      <= (cmd.op == OP_INIT);
				cmd_idx_q <= '0;
				ph_q      <= PH_HI_EN;
			end else if (fire) begin
				if (nx_last) begin
					busy_q <= 1'b0;
				end else if (pu_q) begin
					pu_q <= 1'b0;
				end else if (ph_q == PH_GAP) begin
					ph_q      <= PH_HI_EN;
					cmd_idx_q <= cmd_idx_q + 1'b1;
				end else if (ph_q == PH_LO_DIS) begin
					ph_q <= PH_GAP;
				end else begin
					ph_q <= ph_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			op_q  <= cmd.op;
			val_q <= cmd.value;
		end
		if (fire) begin
			rs_q   <= nx_rs;
			en_q   <= nx_en;
			nib_q  <= nx_nib;
			hold_q <= nx_hold;
			last_q <= nx_last;
		end
	end

endmodule
